@@ sv/mts_pkg.sv @@
package mts_pkg;

  localparam int MAX_SIDE_DEF = 64;

  localparam int DATA_W = 32;
  localparam int SIZE_W = 7;
  localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;

  // APB: one 32-bit register at byte address 0
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_FETCH = 1'b1
  } mode_t;

  // request held between the sequencer and the result stage
  typedef struct packed {
    logic valid;
    logic fetch;    // 1: fetch, 0: load
    logic restart;  // load that opens a new matrix
    logic cmp;      // load below the diagonal, check against mirror
    logic last;     // final element of the transpose
    logic rdy;      // fetch against a complete matrix
  } stage_req_t;

endpackage

@@ sv/matrix_transpose_symmetry.sv @@
// Fetch path: a fetch request's result passes the memory read register, then the output
//   register; a load request gives no result.
// Throughput: one request per cycle, loads and fetches mixed, while the result stream is
//   not back-pressured; set by the single write/read port pair of the element memory.
// Reset: synchronous, active low; size returns to 64, positions to zero, matrix marked
//   not loaded and symmetric. Element memory is not cleared.
module matrix_transpose_symmetry #(
  parameter int MAX_SIDE = mts_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mts_pkg::DATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic                        in_tuser,   // [0] mode
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mts_pkg::DATA_W-1:0]  out_tdata,  // [31:0] out_value
  output logic                        out_tlast,
  output logic [1:0]                  out_tuser,  // [0] is_symmetric, [1] ready_res
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mts_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [mts_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [mts_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic                          cfg_wr, cfg_hit;
  logic [mts_pkg::SIZE_W-1:0]    size;
  logic                          adv;
  mts_pkg::stage_req_t           req;
  logic [mts_pkg::DATA_W-1:0]    req_value, rd_data, mem_wdata;
  logic                          mem_we, mem_re;
  logic [AW-1:0]                 mem_waddr, mem_raddr;

  // APB: zero wait states; a size write restarts the matrix
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[mts_pkg::CFG_AW-1:2] == mts_pkg::REG_MATRIX_SIZE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? mts_pkg::CFG_DW'(size) : '0;

  // stage 0: positions, memory write and read issue
  mts_seq #(
    .MAX_SIDE (MAX_SIDE),
    .AW       (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cfg_size  (cfg_pwdata[mts_pkg::SIZE_W-1:0]),
    .size_o    (size),
    .in_valid  (in_tvalid),
    .in_mode   (in_tuser),
    .in_value  (in_tdata),
    .in_ready  (in_tready),
    .adv       (adv),
    .req_o     (req),
    .value_o   (req_value),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr)
  );

  // element store; mirror of a lower element is always written by an earlier load
  mts_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (mts_pkg::DATA_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // stage 1: symmetry compare and result register
  mts_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .req       (req),
    .value     (req_value),
    .rd_data   (rd_data),
    .adv       (adv),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_last  (out_tlast),
    .out_sym   (out_tuser[0]),
    .out_rdy   (out_tuser[1])
  );

endmodule

@@ sv/mts_mem.sv @@
module mts_mem #(
  parameter int DEPTH = mts_pkg::MAX_SIDE_DEF * mts_pkg::MAX_SIDE_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = mts_pkg::DATA_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/mts_seq.sv @@
module mts_seq #(
  parameter int MAX_SIDE = mts_pkg::MAX_SIDE_DEF,
  parameter int AW       = $clog2(MAX_SIDE * MAX_SIDE)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr,
  input  logic [mts_pkg::SIZE_W-1:0]  cfg_size,
  output logic [mts_pkg::SIZE_W-1:0]  size_o,
  input  logic                        in_valid,
  input  logic                        in_mode,
  input  logic [mts_pkg::DATA_W-1:0]  in_value,
  output logic                        in_ready,
  input  logic                        adv,
  output mts_pkg::stage_req_t         req_o,
  output logic [mts_pkg::DATA_W-1:0]  value_o,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [mts_pkg::DATA_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr
);

  localparam int RW  = $clog2(MAX_SIDE);
  localparam int NW  = $clog2(MAX_SIDE + 1);
  localparam int SZW = ((NW > mts_pkg::SIZE_W) ? NW : mts_pkg::SIZE_W) + 1;

  logic [mts_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [RW-1:0] load_row_r, load_row_nxt, load_col_r, load_col_nxt;
  logic [RW-1:0] read_row_r, read_row_nxt, read_col_r, read_col_nxt;
  logic          loaded_r, loaded_nxt;
  mts_pkg::stage_req_t req_r, req_nxt;
  logic [mts_pkg::DATA_W-1:0] value_r;

  logic [SZW-1:0] size_x, side_n;
  logic [RW-1:0]  lr, lc;
  logic           accept, is_load;
  logic           lc_end, lr_end, rc_end, rr_end;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
                                            input logic [RW-1:0] col);
    addr_of = AW'(row) * AW'(MAX_SIDE) + AW'(col);
  endfunction

  // side clamped to 1..MAX_SIDE
  always_comb begin
    size_x = SZW'(size_r);
    if (size_r == '0) begin
      side_n = SZW'(1);
    end else if (size_x > SZW'(MAX_SIDE)) begin
      side_n = SZW'(MAX_SIDE);
    end else begin
      side_n = size_x;
    end
  end

  assign in_ready = !req_r.valid || adv;
  assign accept   = in_valid && in_ready;
  assign is_load  = (mts_pkg::mode_t'(in_mode) == mts_pkg::MODE_LOAD);

  // a load after a complete matrix starts over at the origin
  assign lr = loaded_r ? '0 : load_row_r;
  assign lc = loaded_r ? '0 : load_col_r;

  assign lc_end = (SZW'(lc) + SZW'(1)) >= side_n;
  assign lr_end = (SZW'(lr) + SZW'(1)) >= side_n;
  assign rc_end = (SZW'(read_col_r) + SZW'(1)) >= side_n;
  assign rr_end = (SZW'(read_row_r) + SZW'(1)) >= side_n;

  always_comb begin
    size_nxt     = size_r;
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    read_row_nxt = read_row_r;
    read_col_nxt = read_col_r;
    loaded_nxt   = loaded_r;
    req_nxt      = req_r;
    if (adv) begin
      req_nxt.valid = 1'b0;
    end
    if (cfg_wr) begin
      size_nxt     = cfg_size;
      load_row_nxt = '0;
      load_col_nxt = '0;
      read_row_nxt = '0;
      read_col_nxt = '0;
      loaded_nxt   = 1'b0;
    end else if (accept) begin
      req_nxt.valid   = 1'b1;
      req_nxt.fetch   = !is_load;
      req_nxt.restart = is_load && loaded_r;
      req_nxt.cmp     = is_load && (lr > lc);
      req_nxt.last    = !is_load && loaded_r && rc_end && rr_end;
      req_nxt.rdy     = !is_load && loaded_r;
      if (is_load) begin
        if (loaded_r) begin
          read_row_nxt = '0;
          read_col_nxt = '0;
        end
        loaded_nxt = 1'b0;
        if (lc_end) begin
          load_col_nxt = '0;
          if (lr_end) begin
            load_row_nxt = '0;
            loaded_nxt   = 1'b1;
          end else begin
            load_row_nxt = lr + RW'(1);
          end
        end else begin
          load_row_nxt = lr;
          load_col_nxt = lc + RW'(1);
        end
      end else if (loaded_r) begin
        if (rc_end) begin
          read_col_nxt = '0;
          read_row_nxt = rr_end ? '0 : read_row_r + RW'(1);
        end else begin
          read_col_nxt = read_col_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= mts_pkg::SIZE_RST;
      load_row_r <= '0;
      load_col_r <= '0;
      read_row_r <= '0;
      read_col_r <= '0;
      loaded_r   <= 1'b0;
      req_r      <= '0;
    end else begin
      size_r     <= size_nxt;
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      read_row_r <= read_row_nxt;
      read_col_r <= read_col_nxt;
      loaded_r   <= loaded_nxt;
      req_r      <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_value;
    end
  end

  // load writes (r,c) and reads mirror (c,r); fetch reads (col,row)
  assign mem_we    = accept && is_load && !cfg_wr;
  assign mem_waddr = addr_of(lr, lc);
  assign mem_wdata = in_value;
  assign mem_re    = accept;
  assign mem_raddr = is_load ? addr_of(lc, lr) : addr_of(read_col_r, read_row_r);

  assign size_o  = size_r;
  assign req_o   = req_r;
  assign value_o = value_r;

endmodule

@@ sv/mts_out.sv @@
module mts_out (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr,
  input  mts_pkg::stage_req_t        req,
  input  logic [mts_pkg::DATA_W-1:0] value,
  input  logic [mts_pkg::DATA_W-1:0] rd_data,
  output logic                       adv,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mts_pkg::DATA_W-1:0] out_value,
  output logic                       out_last,
  output logic                       out_sym,
  output logic                       out_rdy
);

  logic sym_r, sym_nxt, sym_base;
  logic out_valid_r, out_valid_nxt;
  logic [mts_pkg::DATA_W-1:0] out_value_r;
  logic out_last_r, out_sym_r, out_rdy_r;
  logic take;

  // IEEE equality: NaN never equal, signed zeros equal
  function automatic logic fp_eq(input logic [31:0] a, input logic [31:0] b);
    logic nan_a, nan_b;
    nan_a = a[30:0] > 31'h7F80_0000;
    nan_b = b[30:0] > 31'h7F80_0000;
    if (nan_a || nan_b) begin
      fp_eq = 1'b0;
    end else if ((a[30:0] | b[30:0]) == '0) begin
      fp_eq = 1'b1;
    end else begin
      fp_eq = (a == b);
    end
  endfunction

  assign adv  = req.valid && (!req.fetch || !out_valid_r || out_ready);
  assign take = adv && req.fetch;

  always_comb begin
    sym_base = req.restart ? 1'b1 : sym_r;
    sym_nxt  = sym_r;
    if (cfg_wr) begin
      sym_nxt = 1'b1;
    end else if (adv && !req.fetch) begin
      sym_nxt = sym_base && (!req.cmp || fp_eq(value, rd_data));
    end
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      sym_r       <= sym_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_value_r <= req.rdy ? rd_data : '0;
      out_last_r  <= req.last;
      out_sym_r   <= req.rdy && sym_r;
      out_rdy_r   <= req.rdy;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_sym   = out_sym_r;
  assign out_rdy   = out_rdy_r;

endmodule

@@ sv/mts_checker.sv @@
module mts_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tuser,
  input logic                        out_tvalid,
  input logic [mts_pkg::DATA_W-1:0]  out_tdata,
  input logic                        out_tlast,
  input logic [1:0]                  out_tuser,
  input logic                        cfg_psel,
  input logic                        cfg_penable,
  input logic                        cfg_pwrite,
  input logic [mts_pkg::CFG_AW-1:0]  cfg_paddr,
  input logic [mts_pkg::CFG_DW-1:0]  cfg_pwdata,
  input logic [mts_pkg::CFG_DW-1:0]  cfg_prdata,
  input logic                        cfg_pready
);

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // fetch before a complete load carries only zeros
  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata == '0 && !out_tlast && !out_tuser[0])
    else $error("not-ready result carries data");

  // size register reads back what was written
  a_size_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
      && cfg_paddr[mts_pkg::CFG_AW-1:2] == mts_pkg::REG_MATRIX_SIZE
    |=> cfg_prdata[mts_pkg::SIZE_W-1:0] == $past(cfg_pwdata[mts_pkg::SIZE_W-1:0]))
    else $error("size register readback mismatch");

  // a fresh result follows a fetch request through the request register and the output register
  a_fetch_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser, 2))
    else $error("result without matching fetch");

endmodule

bind matrix_transpose_symmetry mts_checker u_mts_checker (.*);

@@ tb/tb_matrix_transpose_symmetry.sv @@
module tb_matrix_transpose_symmetry;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W         = mts_pkg::DATA_W;
  localparam int SIZE_W         = mts_pkg::SIZE_W;
  localparam int CFG_AW         = mts_pkg::CFG_AW;
  localparam int CFG_DW         = mts_pkg::CFG_DW;
  localparam int SIDE_MAX       = mts_pkg::MAX_SIDE_DEF;
  localparam logic [SIZE_W-1:0] SIZE_RST = mts_pkg::SIZE_RST;
  localparam int DRAIN_CYCLES   = 8;     // margin for the last requests to retire
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before we give up
  localparam int RANDOM_REQS    = 1300;  // random requests in the mixed-size pass
  localparam logic [CFG_AW-1:0] SIZE_ADDR = CFG_AW'({mts_pkg::REG_MATRIX_SIZE, 2'b00});

  // ---------------------------------------------------------------------------
  // DUT ports; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata    = '0;   // [31:0] value
  logic              in_tuser    = 1'b0; // [0] mode
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [DATA_W-1:0] out_tdata;          // [31:0] out_value
  logic              out_tlast;
  logic [1:0]        out_tuser;          // [0] is_symmetric, [1] ready_res
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  always #6 clk = ~clk;

  matrix_transpose_symmetry #(.MAX_SIDE(SIDE_MAX)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Transpose predictor: shadow store, load/read cursors and flags
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              sym;
    logic              rdy;
  } xpose_elem_t;

  xpose_elem_t       xpose_q [$];        // transposed elements still owed by the DUT
  logic [DATA_W-1:0] elem_mem [SIDE_MAX*SIDE_MAX];
  logic [SIZE_W-1:0] side_reg;
  int unsigned       ld_row, ld_col, rd_row, rd_col;
  bit                sym_flag, full_flag;

  // run statistics
  int unsigned loads_sent, fetches_sent, early_fetches, cfg_writes;
  int unsigned mats_done, mats_asym, widest;
  int unsigned err_count;

  // traffic shaping
  bit          steady = 1'b0;  // no gaps on either side while set
  int unsigned rx_hold = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned eff_side();
    // 0 behaves as 1, anything above the store side is clamped
    if (side_reg == '0) return 1;
    if (32'(side_reg) > SIDE_MAX) return SIDE_MAX;
    return 32'(side_reg);
  endfunction

  function automatic void restart_matrix();
    ld_row    = 0;
    ld_col    = 0;
    rd_row    = 0;
    rd_col    = 0;
    sym_flag  = 1'b1;
    full_flag = 1'b0;
  endfunction

  function automatic bit is_nan(input logic [DATA_W-1:0] x);
    return (x & 32'h7FFF_FFFF) > 32'h7F80_0000;
  endfunction

  // float ==: NaN never matches, the two zeros match
  function automatic bit fp_equal(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (((a | b) & 32'h7FFF_FFFF) == '0) return 1'b1;
    return a == b;
  endfunction

  function automatic void predict_request(input mts_pkg::mode_t m,
                                          input logic [DATA_W-1:0] v);
    int unsigned n;
    bit          end_col, end_row;
    xpose_elem_t r;
    n = eff_side();
    if (m == mts_pkg::MODE_LOAD) begin
      loads_sent++;
      if (full_flag) restart_matrix();  // load after a complete matrix opens a new one
      elem_mem[ld_row*SIDE_MAX + ld_col] = v;
      if (ld_row > ld_col && !fp_equal(v, elem_mem[ld_col*SIDE_MAX + ld_row]))
        sym_flag = 1'b0;
      if (ld_col + 1 >= n) begin
        ld_col = 0;
        if (ld_row + 1 >= n) begin
          ld_row    = 0;
          full_flag = 1'b1;
          mats_done++;
          if (!sym_flag) mats_asym++;
          if (n > widest) widest = n;
        end else begin
          ld_row++;
        end
      end else begin
        ld_col++;
      end
    end else begin
      fetches_sent++;
      r = '0;
      if (full_flag) begin
        end_col = (rd_col + 1 >= n);
        end_row = (rd_row + 1 >= n);
        r.value = elem_mem[rd_col*SIDE_MAX + rd_row];
        r.last  = end_col && end_row;
        r.sym   = sym_flag;
        r.rdy   = 1'b1;
        if (end_col) begin
          rd_col = 0;
          rd_row = end_row ? 0 : rd_row + 1;
        end else begin
          rd_col++;
        end
      end else begin
        early_fetches++;  // not ready: all-zero result, no state change
      end
      xpose_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    err_count++;
    $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    xpose_elem_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (xpose_q.size() == 0) begin
        report_mismatch("result with no fetch pending", out_tdata, '0);
      end else begin
        want = xpose_q.pop_front();
        if (out_tdata !== want.value) report_mismatch("out_value", out_tdata, want.value);
        if (out_tlast !== want.last)
          report_mismatch("out_last", DATA_W'(out_tlast), DATA_W'(want.last));
        if (out_tuser[0] !== want.sym)
          report_mismatch("is_symmetric", DATA_W'(out_tuser[0]), DATA_W'(want.sym));
        if (out_tuser[1] !== want.rdy)
          report_mismatch("ready_res", DATA_W'(out_tuser[1]), DATA_W'(want.rdy));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle/stall shaping: mostly none, some short, a few long
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_idle(input int unsigned zero_pct);
    int unsigned p;
    if (steady) return 0;
    p = $urandom_range(99);
    if (p < zero_pct) return 0;
    if (p < 97) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result-side backpressure
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_hold = pick_idle(75);
    end
  end

  // watchdog: any handshake on any port counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake, %0d results owed",
               quiet_cycles, xpose_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver. tvalid is only dropped when a gap follows, so a back-to-back
  // request never sees a low and a high NBA in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input mts_pkg::mode_t m, input logic [DATA_W-1:0] v);
    int unsigned gap;
    gap = pick_idle(65);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    predict_request(m, v);
  endtask

  task automatic send_fetches(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_request(mts_pkg::MODE_FETCH, $urandom());
  endtask

  // stop sending, let every owed result arrive, then let the last loads retire
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (xpose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Config port: setup + access, then an idle cycle
  // ---------------------------------------------------------------------------
  task automatic cfg_access(input logic wr, input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= SIZE_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // size write restarts the block; read back to check the register
  task automatic set_side(input logic [SIZE_W-1:0] s);
    logic [CFG_DW-1:0] rd;
    wait_idle();
    cfg_access(1'b1, CFG_DW'(s), rd);
    side_reg = s;
    restart_matrix();
    cfg_writes++;
    cfg_access(1'b0, '0, rd);
    if (rd !== CFG_DW'(s)) report_mismatch("matrix_size readback", rd, CFG_DW'(s));
  endtask

  // ---------------------------------------------------------------------------
  // Matrix content
  // ---------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] pick_element();
    logic s;
    s = 1'($urandom_range(1));
    case ($urandom_range(39))
      0, 1:       return {s, 31'h0};                               // signed zeros
      2:          return {s, 8'hFF, 23'($urandom) | 23'h1};        // NaN
      3:          return {s, 8'hFF, 23'h0};                        // infinities
      4, 5, 6, 7: begin
        // small pool so unrelated cells collide now and then
        case ($urandom_range(3))
          0:       return 32'h3F80_0000;
          1:       return 32'h4000_0000;
          2:       return 32'hBF80_0000;
          default: return 32'h0000_0001;
        endcase
      end
      default:    return $urandom();
    endcase
  endfunction

  // mirror copy; a zero may come back with the other sign
  function automatic logic [DATA_W-1:0] mirror_of(input logic [DATA_W-1:0] v);
    logic s;
    s = 1'($urandom_range(1));
    if (v[30:0] == '0) return {s, 31'h0};
    return v;
  endfunction

  // Load up to stop_at elements of a matrix at the current side, row-major.
  // mirrored: lower triangle copies the upper one, sometimes with one pair spoiled.
  // noise_pct: chance of a stray fetch ahead of each load.
  task automatic load_matrix(input bit mirrored, input int unsigned stop_at,
                             input int unsigned noise_pct);
    logic [DATA_W-1:0] cells [SIDE_MAX*SIDE_MAX];
    int unsigned       n, bad_r, bad_c;
    n = eff_side();
    for (int unsigned r = 0; r < n; r++) begin
      for (int unsigned c = 0; c < n; c++) begin
        if (mirrored && r > c) cells[r*n + c] = mirror_of(cells[c*n + r]);
        else cells[r*n + c] = pick_element();
      end
    end
    if (mirrored && n > 1 && $urandom_range(3) == 0) begin
      bad_r = $urandom_range(n - 1, 1);
      bad_c = $urandom_range(bad_r - 1);
      cells[bad_r*n + bad_c] = $urandom();
    end
    for (int unsigned i = 0; i < n*n && i < stop_at; i++) begin
      if ($urandom_range(99) < noise_pct) send_request(mts_pkg::MODE_FETCH, $urandom());
      send_request(mts_pkg::MODE_LOAD, cells[i]);
    end
  endtask

  function automatic logic [SIZE_W-1:0] random_side();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 5) return '0;
    if (p < 75) return SIZE_W'($urandom_range(4, 1));
    if (p < 95) return SIZE_W'($urandom_range(12, 5));
    return SIZE_W'($urandom_range(16, 13));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // size register at its reset value; a fetch with nothing loaded is not ready
  task automatic test_reset_state();
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b0, '0, rd);
    if (rd !== CFG_DW'(SIZE_RST))
      report_mismatch("matrix_size after reset", rd, CFG_DW'(SIZE_RST));
    send_request(mts_pkg::MODE_FETCH, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  // 2x2: +0/-0 pair is symmetric, a NaN pair is not; fetch before complete;
  // load after a complete matrix starts over; read wraps
  task automatic test_zero_sign_and_nan();
    set_side(SIZE_W'(2));
    send_request(mts_pkg::MODE_LOAD, 32'hFFFF_FFFF);   // diagonal NaN is never compared
    send_request(mts_pkg::MODE_LOAD, 32'h0000_0000);
    send_request(mts_pkg::MODE_LOAD, 32'h8000_0000);
    send_request(mts_pkg::MODE_LOAD, 32'h7F80_0000);
    send_fetches(5);                                   // last on the 4th, then wrap
    send_request(mts_pkg::MODE_LOAD, 32'h3F80_0000);   // opens a new matrix
    send_request(mts_pkg::MODE_LOAD, 32'h7FC0_0000);
    send_request(mts_pkg::MODE_FETCH, 32'h0);          // half loaded: not ready
    send_request(mts_pkg::MODE_LOAD, 32'h7FC0_0000);   // NaN against NaN: asymmetric
    send_request(mts_pkg::MODE_LOAD, 32'h0000_0000);
    send_request(mts_pkg::MODE_FETCH, 32'h0);
    wait_idle();
  endtask

  // size 0 acts as 1; a 1x1 matrix completes after one load and is symmetric
  task automatic test_smallest_sides();
    set_side('0);
    send_request(mts_pkg::MODE_LOAD, 32'h1234_5678);
    send_fetches(2);
    set_side(SIZE_W'(1));
    send_request(mts_pkg::MODE_LOAD, 32'hFFC0_0001);
    send_fetches(1);
    wait_idle();
  endtask

  // mostly well-formed load/fetch sequences at small sizes, some abandoned loads,
  // stray fetches, size changes between matrices
  task automatic test_random_matrices();
    int unsigned start, n;
    start = loads_sent + fetches_sent;
    while (loads_sent + fetches_sent - start < RANDOM_REQS) begin
      steady = ($urandom_range(4) == 0);
      if ($urandom_range(3) == 0) set_side(random_side());
      n = eff_side();
      if ($urandom_range(9) == 0) begin
        // broken sequence: partial load, then a size write restarts everything
        load_matrix(1'($urandom_range(1)), $urandom_range(n*n), 10);
        set_side(random_side());
      end else begin
        load_matrix($urandom_range(4) != 0, n*n, 5);
        if ($urandom_range(1) == 0) send_fetches(n*n + $urandom_range(n));
        else send_fetches($urandom_range(n*n, 1));
        if ($urandom_range(5) == 0) wait_idle();  // sender holds until all results are back
      end
    end
    steady = 1'b0;
    wait_idle();
  endtask

  // out-of-range size clamps to the full store: a partial load runs across
  // two row ends, fetches stay not ready; then size 64 with an abandoned load
  task automatic test_largest_side();
    set_side(7'h7F);
    load_matrix(1'b1, 150, 0);
    send_fetches(2);
    set_side(SIZE_W'(SIDE_MAX));
    load_matrix(1'b0, 60, 20);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    side_reg = SIZE_RST;
    restart_matrix();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_zero_sign_and_nan();
    test_smallest_sides();
    test_random_matrices();
    test_largest_side();

    wait_idle();
    $display("covered %0d requests: %0d loads, %0d fetches (%0d not ready), %0d size writes",
             loads_sent + fetches_sent, loads_sent, fetches_sent, early_fetches, cfg_writes);
    $display("%0d matrices completed, %0d asymmetric, widest side %0d",
             mats_done, mats_asym, widest);
    if (err_count == 0 && xpose_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mts_pkg.sv
sv/mts_mem.sv
sv/mts_seq.sv
sv/mts_out.sv
sv/matrix_transpose_symmetry.sv
sv/mts_checker.sv
tb/tb_matrix_transpose_symmetry.sv
